FILE: sv/zci_pkg.sv
// shared widths, queue depth and result method codes for the zero-crossing interpolator
`timescale 1ns / 1ps

package zci_pkg;

    // default field widths
    localparam int VOLTAGE_BITS_DEF = 24;
    localparam int SPEED_BITS_DEF   = 32;

    // depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // how the result voltage was found
    typedef enum logic [1:0] {
        METHOD_EXACT   = 2'd0,
        METHOD_INTERP  = 2'd1,
        METHOD_NEAREST = 2'd2
    } method_t;

endpackage

FILE: sv/zci_front.sv
// front end: takes scan points, tracks the deciding event and queues one command per scan
`timescale 1ns / 1ps

module zci_front #(
    parameter int VOLTAGE_BITS = zci_pkg::VOLTAGE_BITS_DEF,
    parameter int SPEED_BITS   = zci_pkg::SPEED_BITS_DEF,
    parameter int IN_W         = ((VOLTAGE_BITS + SPEED_BITS + 7) / 8) * 8,
    parameter int CMD_W        = 2 * VOLTAGE_BITS + 2 * SPEED_BITS + 5
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             s_tlast,
    input  logic             q_full,
    output logic             q_push,
    output logic [CMD_W-1:0] q_data
);

    localparam int V = VOLTAGE_BITS;
    localparam int S = SPEED_BITS;

    logic signed [V-1:0] v_in;
    logic signed [S-1:0] s_in;
    logic [S-1:0]        abs_s;
    logic [S-1:0]        abs_p;
    logic [V:0]          dv;
    logic [V:0]          abs_dv;
    logic [S:0]          den;
    logic                s_pos, s_neg, p_pos, p_neg;
    logic                sign_chg;
    logic                accept;

    logic signed [V-1:0] prev_v_reg, prev_v_next;
    logic signed [S-1:0] prev_s_reg, prev_s_next;
    logic                have_prev_reg, have_prev_next;
    logic                decided_reg, decided_next;
    zci_pkg::method_t    dec_m_reg, dec_m_next;
    logic [V-1:0]        dec_v_reg, dec_v_next;
    logic [S-1:0]        a_reg, a_next;
    logic [V:0]          b_reg, b_next;
    logic [S:0]          c_reg, c_next;
    logic                neg_reg, neg_next;
    logic [S-1:0]        best_abs_reg, best_abs_next;
    logic [V-1:0]        best_v_reg, best_v_next;

    assign v_in = s_tdata[V-1:0];
    assign s_in = s_tdata[V+S-1:V];

    assign abs_s = s_in[S-1] ? (~unsigned'(s_in) + S'(1)) : unsigned'(s_in);
    assign abs_p = prev_s_reg[S-1] ? (~unsigned'(prev_s_reg) + S'(1)) : unsigned'(prev_s_reg);

    assign s_neg = s_in[S-1];
    assign s_pos = !s_in[S-1] && (s_in != '0);
    assign p_neg = prev_s_reg[S-1];
    assign p_pos = !prev_s_reg[S-1] && (prev_s_reg != '0);

    assign sign_chg = have_prev_reg && ((p_neg && s_pos) || (p_pos && s_neg));

    // voltage step and its magnitude, one bit wider than a voltage
    assign dv     = {v_in[V-1], v_in} - {prev_v_reg[V-1], prev_v_reg};
    assign abs_dv = dv[V] ? (~dv + (V+1)'(1)) : dv;
    assign den    = {1'b0, abs_p} + {1'b0, abs_s};

    always_comb begin
        prev_v_next    = prev_v_reg;
        prev_s_next    = prev_s_reg;
        have_prev_next = have_prev_reg;
        decided_next   = decided_reg;
        dec_m_next     = dec_m_reg;
        dec_v_next     = dec_v_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        neg_next       = neg_reg;
        best_abs_next  = best_abs_reg;
        best_v_next    = best_v_reg;
        if (!decided_reg) begin
            priority if (sign_chg) begin
                decided_next = 1'b1;
                dec_m_next   = zci_pkg::METHOD_INTERP;
                dec_v_next   = prev_v_reg;
                a_next       = abs_p;
                b_next       = abs_dv;
                c_next       = den;
                neg_next     = dv[V];
            end else if (s_in == '0) begin
                decided_next = 1'b1;
                dec_m_next   = zci_pkg::METHOD_EXACT;
                dec_v_next   = v_in;
            end else begin
                decided_next = decided_reg;
            end
            if (abs_s < best_abs_reg) begin
                best_abs_next = abs_s;
                best_v_next   = v_in;
            end
            prev_v_next    = v_in;
            prev_s_next    = s_in;
            have_prev_next = 1'b1;
        end
    end

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept && s_tlast;

    // command: voltage, method, then divider operands and sign of the step
    assign q_data = decided_next ?
        {neg_next, c_next, b_next, a_next, dec_m_next, dec_v_next} :
        {neg_next, c_next, b_next, a_next, zci_pkg::METHOD_NEAREST, best_v_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_prev_reg <= 1'b0;
            decided_reg   <= 1'b0;
            best_abs_reg  <= '1;
        end else if (accept) begin
            if (s_tlast) begin
                have_prev_reg <= 1'b0;
                decided_reg   <= 1'b0;
                best_abs_reg  <= '1;
            end else begin
                have_prev_reg <= have_prev_next;
                decided_reg   <= decided_next;
                best_abs_reg  <= best_abs_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && !s_tlast) begin
            prev_v_reg <= prev_v_next;
            prev_s_reg <= prev_s_next;
            dec_m_reg  <= dec_m_next;
            dec_v_reg  <= dec_v_next;
            a_reg      <= a_next;
            b_reg      <= b_next;
            c_reg      <= c_next;
            neg_reg    <= neg_next;
            best_v_reg <= best_v_next;
        end
    end

endmodule

FILE: sv/zci_fifo.sv
// small show-ahead command queue between front and back
`timescale 1ns / 1ps

module zci_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = zci_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == (PTR_W+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            priority if (do_push && !do_pop) begin
                count_reg <= count_reg + (PTR_W+1)'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - (PTR_W+1)'(1);
            end else begin
                count_reg <= count_reg;
            end
        end
    end

endmodule

FILE: sv/zci_back.sv
// back end: runs the serial multiply-divide for interpolation and holds the result beat
`timescale 1ns / 1ps

module zci_back #(
    parameter int VOLTAGE_BITS = zci_pkg::VOLTAGE_BITS_DEF,
    parameter int SPEED_BITS   = zci_pkg::SPEED_BITS_DEF,
    parameter int OUT_W        = ((VOLTAGE_BITS + 2 + 7) / 8) * 8,
    parameter int CMD_W        = 2 * VOLTAGE_BITS + 2 * SPEED_BITS + 5
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_empty,
    output logic              q_pop,
    input  logic [CMD_W-1:0]  q_data,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata
);

    localparam int V     = VOLTAGE_BITS;
    localparam int S     = SPEED_BITS;
    localparam int STEPS = V + 1;
    localparam int CNT_W = $clog2(STEPS);

    typedef enum logic {ST_IDLE, ST_DIV} state_t;

    state_t           st_reg;
    logic             m_tvalid_reg;
    logic [V-1:0]     out_v_reg;
    zci_pkg::method_t out_m_reg;

    logic [V-1:0]     cmd_v;
    zci_pkg::method_t cmd_m;
    logic [S-1:0]     cmd_a;
    logic [V:0]       cmd_b;
    logic [S:0]       cmd_c;
    logic             cmd_neg;

    logic [S-1:0]     a_reg;
    logic [V:0]       b_reg;
    logic [S:0]       c_reg;
    logic [S:0]       r_reg, r_next;
    logic [V:0]       q_reg, q_next;
    logic [V-1:0]     v0_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [S+2:0]     r2, c1, c2, r_sub;
    logic             ge1, ge2;
    logic [1:0]       digit;
    logic [V:0]       res;
    logic             out_load;

    assign cmd_v   = q_data[V-1:0];
    assign cmd_m   = zci_pkg::method_t'(q_data[V+1:V]);
    assign cmd_a   = q_data[V+2 +: S];
    assign cmd_b   = q_data[V+2+S +: V+1];
    assign cmd_c   = q_data[2*V+3+S +: S+1];
    assign cmd_neg = q_data[2*V+2*S+4];

    // one quotient bit a cycle: shift in a times the next bit of b, then remove c or 2c
    assign r2    = {1'b0, r_reg, 1'b0} + (b_reg[V] ? {3'b000, a_reg} : '0);
    assign c1    = {2'b00, c_reg};
    assign c2    = {1'b0, c_reg, 1'b0};
    assign ge2   = (r2 >= c2);
    assign ge1   = (r2 >= c1);
    assign r_sub = ge2 ? (r2 - c2) : (ge1 ? (r2 - c1) : r2);
    assign digit = ge2 ? 2'd2 : (ge1 ? 2'd1 : 2'd0);
    assign r_next = r_sub[S:0];
    assign q_next = {q_reg[V-1:0], 1'b0} + {{(V-1){1'b0}}, digit};

    // the offset stays between the two points, so the sum fits a voltage
    assign res = neg_reg ? ({v0_reg[V-1], v0_reg} - q_next) : ({v0_reg[V-1], v0_reg} + q_next);

    assign q_pop    = (st_reg == ST_IDLE) && !q_empty && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'({out_m_reg, out_v_reg});

    // a new result beat is loaded straight from the queue or at the last divide step
    assign out_load = ((st_reg == ST_IDLE) && q_pop && (cmd_m != zci_pkg::METHOD_INTERP)) ||
                      ((st_reg == ST_DIV) && (cnt_reg == CNT_W'(STEPS - 1)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= out_load || (m_tvalid_reg && !m_tready);
            unique case (st_reg)
                ST_IDLE: begin
                    if (q_pop) begin
                        if (cmd_m == zci_pkg::METHOD_INTERP) begin
                            st_reg  <= ST_DIV;
                            a_reg   <= cmd_a;
                            b_reg   <= cmd_b;
                            c_reg   <= cmd_c;
                            v0_reg  <= cmd_v;
                            neg_reg <= cmd_neg;
                            r_reg   <= '0;
                            q_reg   <= '0;
                            cnt_reg <= '0;
                        end else begin
                            out_v_reg <= cmd_v;
                            out_m_reg <= cmd_m;
                        end
                    end
                end
                ST_DIV: begin
                    r_reg   <= r_next;
                    q_reg   <= q_next;
                    b_reg   <= {b_reg[V-1:0], 1'b0};
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(STEPS - 1)) begin
                        st_reg    <= ST_IDLE;
                        out_v_reg <= res[V-1:0];
                        out_m_reg <= zci_pkg::METHOD_INTERP;
                    end
                end
                default: begin
                    st_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: sv/zero_crossing_interpolator.sv
// top level of the zero-crossing interpolator: front end, command queue and back end
`timescale 1ns / 1ps

// Finds the drive voltage at which measured speed crosses zero over one scan of
// points. Each input beat carries one point (voltage Q4.20, speed Q24.8) and tlast
// marks the final point; exactly one result beat comes out per scan, after its last
// point. The result comes from the earlier of the first exact-zero point (method 0)
// and the linear interpolation across the first strict sign change (method 1, quotient
// truncated toward zero), else the earliest point of smallest absolute speed (method 2).
// Points arrive at up to one beat per cycle while the queue has room: the front end
// classifies each point as it is accepted. Exact and nearest results are offered at
// the output the cycle after the back end takes them from the queue; an interpolated
// result waits for the bit-serial multiply-divide, which forms one quotient bit per
// cycle. A two-entry queue sits between front and back, so the input only stalls when
// two scan results are waiting behind a busy divider or a held output beat.

module zero_crossing_interpolator #(
    parameter int VOLTAGE_BITS = zci_pkg::VOLTAGE_BITS_DEF,
    parameter int SPEED_BITS   = zci_pkg::SPEED_BITS_DEF,
    localparam int IN_W        = ((VOLTAGE_BITS + SPEED_BITS + 7) / 8) * 8,
    localparam int OUT_W       = ((VOLTAGE_BITS + 2 + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    // scan points
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // drive_voltage, measured_speed, zero pad
    input  logic             s_tlast,   // last_point
    // results
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // zero_voltage, method, zero pad
);

    // command word: voltage, method, multiplicand, multiplier, divisor, step sign
    localparam int CMD_W = 2 * VOLTAGE_BITS + 2 * SPEED_BITS + 5;

    logic             q_push, q_pop, q_full, q_empty;
    logic [CMD_W-1:0] q_wr_data, q_rd_data;

    // point tracking, one point per cycle while the queue has room
    zci_front #(
        .VOLTAGE_BITS (VOLTAGE_BITS),
        .SPEED_BITS   (SPEED_BITS),
        .IN_W         (IN_W),
        .CMD_W        (CMD_W)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wr_data)
    );

    // decouples scan ends from the divider
    zci_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (zci_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_data (q_wr_data),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    // divider and output register
    zci_back #(
        .VOLTAGE_BITS (VOLTAGE_BITS),
        .SPEED_BITS   (SPEED_BITS),
        .OUT_W        (OUT_W),
        .CMD_W        (CMD_W)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .q_data   (q_rd_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: sv/zci_checker.sv
// port-level checks on the result channel of the zero-crossing interpolator
`timescale 1ns / 1ps

module zci_checker #(
    parameter int VOLTAGE_BITS = zci_pkg::VOLTAGE_BITS_DEF,
    localparam int OUT_W       = ((VOLTAGE_BITS + 2 + 7) / 8) * 8
) (
    input logic             aclk,
    input logic             aresetn,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    // no result beat straight out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat shown after reset");

    // only the three defined methods ever appear
    a_method_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[VOLTAGE_BITS+1:VOLTAGE_BITS] <= 2'(zci_pkg::METHOD_NEAREST)))
        else $error("undefined method code on result beat");

    // a stalled beat stays offered
    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat withdrawn while stalled");

    // a stalled beat keeps its data
    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result beat changed while stalled");

endmodule

bind zero_crossing_interpolator zci_checker #(
    .VOLTAGE_BITS (VOLTAGE_BITS)
) u_zci_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: test/zero_crossing_interpolator_test.sv
// self-checking testbench for the zero-crossing interpolator: directed table then random scans
`timescale 1ns / 1ps

module zero_crossing_interpolator_test;

    localparam int VOLT_W       = zci_pkg::VOLTAGE_BITS_DEF;
    localparam int SPEED_W      = zci_pkg::SPEED_BITS_DEF;
    localparam int IN_W         = ((VOLT_W + SPEED_W + 7) / 8) * 8;
    localparam int OUT_W        = ((VOLT_W + 2 + 7) / 8) * 8;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_POINTS = 600;
    localparam int QUIET_FROM   = 500;   // no idling on either side past this point count
    localparam int HOLD_CYCLES  = 300;   // long output back-pressure stretch
    localparam int IDLE_LIMIT   = 4000;  // cycles without any beat before giving up
    localparam int DRAIN_CYCLES = 40;    // settle time after the last owed result
    localparam int MAX_REPORTS  = 10;
    localparam int N_ROWS       = 22;

    // one expected result beat
    typedef struct packed {
        logic [VOLT_W-1:0] volt;
        zci_pkg::method_t  meth;
    } crossing_t;

    // one row of the directed table; want_* only used when typed is set
    typedef struct packed {
        logic [VOLT_W-1:0]  volt;
        logic [SPEED_W-1:0] speed;
        bit                 last;
        bit                 typed;
        logic [VOLT_W-1:0]  want_volt;
        zci_pkg::method_t   want_meth;
    } point_row_t;

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;    // drive_voltage, measured_speed, zero pad
    logic             s_tlast;    // last_point
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;    // zero_voltage, method, zero pad

    zero_crossing_interpolator u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // free-running clock, 20 ns period
    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // scan state of the predictor, mirrors the block's own registers
    logic signed [VOLT_W-1:0]  prev_volt;
    logic signed [SPEED_W-1:0] prev_speed;
    bit                        have_prev;
    bit                        scan_decided;
    logic [VOLT_W-1:0]         decided_volt;
    zci_pkg::method_t          decided_meth;
    longint unsigned           best_mag;
    logic [VOLT_W-1:0]         best_volt;

    crossing_t  crossing_q[$];       // results still owed by the block
    point_row_t directed_rows [0:N_ROWS-1];
    int         mismatches;
    int         points_sent;
    bit         quiet;               // end of run: no idling
    bit         hold_pending;        // asks the receiver for one long hold-off

    function automatic void clear_scan();
        prev_volt    = '0;
        prev_speed   = '0;
        have_prev    = 1'b0;
        scan_decided = 1'b0;
        decided_volt = '0;
        decided_meth = zci_pkg::METHOD_EXACT;
        best_mag     = (64'd1 << SPEED_W) - 64'd1;
        best_volt    = '0;
    endfunction

    // fold one point into the scan; on the last point hand back the result
    function automatic bit fold_point(input logic [VOLT_W-1:0] v_raw,
                                      input logic [SPEED_W-1:0] s_raw,
                                      input bit last, output crossing_t res);
        longint v, s, pv, ps, dv;
        longint unsigned mag_s, mag_p, mag_dv, q;
        v  = longint'($signed(v_raw));
        s  = longint'($signed(s_raw));
        pv = longint'(prev_volt);
        ps = longint'(prev_speed);
        res = '0;
        if (!scan_decided) begin
            mag_s = (s < 0) ? longint'(-s) : s;
            if (have_prev && ((ps < 0 && s > 0) || (ps > 0 && s < 0))) begin
                // strict sign change: interpolate, magnitude truncated then signed
                dv     = v - pv;
                mag_p  = (ps < 0) ? longint'(-ps) : ps;
                mag_dv = (dv < 0) ? longint'(-dv) : dv;
                q      = (mag_p * mag_dv) / (mag_p + mag_s);
                decided_volt = (dv < 0) ? VOLT_W'(pv - longint'(q))
                                        : VOLT_W'(pv + longint'(q));
                decided_meth = zci_pkg::METHOD_INTERP;
                scan_decided = 1'b1;
            end else if (s == 0) begin
                decided_volt = v_raw;
                decided_meth = zci_pkg::METHOD_EXACT;
                scan_decided = 1'b1;
            end
            // earliest point of smallest magnitude wins a tie
            if (mag_s < best_mag) begin
                best_mag  = mag_s;
                best_volt = v_raw;
            end
            prev_volt  = v_raw;
            prev_speed = s_raw;
            have_prev  = 1'b1;
        end
        if (!last)
            return 1'b0;
        if (scan_decided) begin
            res.volt = decided_volt;
            res.meth = decided_meth;
        end else begin
            res.volt = best_volt;
            res.meth = zci_pkg::METHOD_NEAREST;
        end
        clear_scan();
        return 1'b1;
    endfunction

    // offer one point and hold it until the block takes it
    task automatic offer_point(input logic [VOLT_W-1:0] v, input logic [SPEED_W-1:0] s,
                               input bit last, input bit typed,
                               input logic [VOLT_W-1:0] want_volt,
                               input zci_pkg::method_t want_meth);
        crossing_t res;
        if (fold_point(v, s, last, res)) begin
            if (typed) begin
                res.volt = want_volt;
                res.meth = want_meth;
            end
            crossing_q.insert(crossing_q.size(), res);
        end
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'({s, v});
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        points_sent++;
    endtask

    // speed of chosen sign with magnitude spread over all bit lengths
    function automatic logic [SPEED_W-1:0] signed_speed(input bit neg);
        logic [SPEED_W-1:0] mag;
        mag = $urandom >> $urandom_range(1, 31);
        if (neg)
            return ~mag;                     // -mag-1, reaches the most negative value
        return (mag == '0) ? SPEED_W'(1) : mag;
    endfunction

    // one random scan: mostly sign sweeps, some one-signed, some with an exact zero, some noise
    task automatic run_random_scan();
        int kind, len, flip_at, i;
        bit neg_first;
        logic [VOLT_W-1:0]  v;
        logic [SPEED_W-1:0] s;
        kind      = $urandom_range(0, 9);
        len       = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 5);
        flip_at   = $urandom_range(1, len);
        neg_first = 1'($urandom_range(0, 1));
        v         = VOLT_W'($urandom);
        for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 1) == 0)
                v = VOLT_W'($urandom);
            else
                v = v + VOLT_W'($urandom_range(0, 2000)) - VOLT_W'(1000);
            if (kind <= 4)
                s = signed_speed((i < flip_at) ? neg_first : !neg_first);
            else if (kind <= 6)
                s = signed_speed(neg_first);
            else if (kind == 7)
                s = (i == flip_at - 1) ? '0 : signed_speed(1'($urandom_range(0, 1)));
            else
                s = $urandom;
            offer_point(v, s, i == len - 1, 1'b0, '0, zci_pkg::METHOD_EXACT);
        end
    endtask

    // main stimulus: reset, directed table, random scans, drain, verdict
    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        mismatches   = 0;
        points_sent  = 0;
        quiet        = 1'b0;
        hold_pending = 1'b0;
        clear_scan();
        directed_rows = '{
            // single-point scans: exact zero, largest and most negative speeds
            '{24'h123456, 32'h00000000, 1'b1, 1'b1, 24'h123456, zci_pkg::METHOD_EXACT},
            '{24'h7FFFFF, 32'h7FFFFFFF, 1'b1, 1'b1, 24'h7FFFFF, zci_pkg::METHOD_NEAREST},
            '{24'h800000, 32'h80000000, 1'b1, 1'b1, 24'h800000, zci_pkg::METHOD_NEAREST},
            // symmetric crossing lands half way
            '{24'h000000, 32'h00000100, 1'b0, 1'b0, 24'h000000, zci_pkg::METHOD_EXACT},
            '{24'h100000, 32'hFFFFFF00, 1'b1, 1'b1, 24'h080000, zci_pkg::METHOD_INTERP},
            // zero mid-scan decides, later points ignored
            '{24'h000064, 32'h00000005, 1'b0, 1'b0, 24'h000000, zci_pkg::METHOD_EXACT},
            '{24'h0000C8, 32'h00000000, 1'b0, 1'b0, 24'h000000, zci_pkg::METHOD_EXACT},
            '{24'h00012C, 32'hFFFFFFF9, 1'b1, 1'b1, 24'h0000C8, zci_pkg::METHOD_EXACT},
            // tie in smallest magnitude keeps the earliest point
            '{24'h00000A, 32'hFFFFFFFD, 1'b0, 1'b0, 24'h000000, zci_pkg::METHOD_EXACT},
            '{24'h000014, 32'hFFFFFFFD, 1'b0, 1'b0, 24'h000000, zci_pkg::METHOD_EXACT},
            '{24'h00001E, 32'hFFFFFFFB, 1'b1, 1'b1, 24'h00000A, zci_pkg::METHOD_NEAREST},
            // widest possible interpolation span
            '{24'h800000, 32'h80000000, 1'b0, 1'b0, 24'h000000, zci_pkg::METHOD_EXACT},
            '{24'h7FFFFF, 32'h7FFFFFFF, 1'b1, 1'b0, 24'h000000, zci_pkg::METHOD_EXACT},
            // zero speed on the last point
            '{24'h000005, 32'h00000007, 1'b0, 1'b0, 24'h000000, zci_pkg::METHOD_EXACT},
            '{24'h000006, 32'h00000000, 1'b1, 1'b1, 24'h000006, zci_pkg::METHOD_EXACT},
            // falling voltage across the crossing
            '{24'h0003E8, 32'h00000003, 1'b0, 1'b0, 24'h000000, zci_pkg::METHOD_EXACT},
            '{24'hFFFC18, 32'hFFFFFFFF, 1'b1, 1'b0, 24'h000000, zci_pkg::METHOD_EXACT},
            // crossing with no voltage step
            '{24'h00002A, 32'h00000001, 1'b0, 1'b0, 24'h000000, zci_pkg::METHOD_EXACT},
            '{24'h00002A, 32'hFFFFFFFF, 1'b1, 1'b1, 24'h00002A, zci_pkg::METHOD_INTERP},
            // all-ones fields, crossing on the third point
            '{24'hFFFFFF, 32'hFFFFFFFF, 1'b0, 1'b0, 24'h000000, zci_pkg::METHOD_EXACT},
            '{24'h000000, 32'hFFFFFFFF, 1'b0, 1'b0, 24'h000000, zci_pkg::METHOD_EXACT},
            '{24'h000001, 32'h00000001, 1'b1, 1'b0, 24'h000000, zci_pkg::METHOD_EXACT}
        };
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < N_ROWS; r++)
            offer_point(directed_rows[r].volt, directed_rows[r].speed, directed_rows[r].last,
                        directed_rows[r].typed, directed_rows[r].want_volt,
                        directed_rows[r].want_meth);

        // random scans; the receiver stalls hard once early on so the input backs up
        hold_pending = 1'b1;
        while (points_sent < N_ROWS + RANDOM_POINTS) begin
            if (points_sent >= N_ROWS + QUIET_FROM)
                quiet = 1'b1;
            run_random_scan();
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        while (crossing_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // receiver: random ready bursts, one long hold-off on request, steady at the end
    initial begin
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // result checker: each result beat against the oldest owed result
    crossing_t want;
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (crossing_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result beat: volt %h method %0d",
                             m_tdata[VOLT_W-1:0], m_tdata[VOLT_W+1:VOLT_W]);
            end else begin
                want = crossing_q.pop_front();
                if (m_tdata[VOLT_W-1:0] !== want.volt ||
                    m_tdata[VOLT_W+1:VOLT_W] !== want.meth) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: expected volt %h method %0d, got volt %h method %0d",
                                 want.volt, want.meth,
                                 m_tdata[VOLT_W-1:0], m_tdata[VOLT_W+1:VOLT_W]);
                end
            end
        end
    end

    // watchdog on cycles where no beat moves on either side
    int idle_cycles;
    initial begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

endmodule
